[sv/mqd_pkg.sv]
// Shared types and constants for the MQTT packet deframer.
package mqd_pkg;

  localparam int unsigned LEN_W = 28;
  localparam int unsigned ID_W  = 16;
  localparam int unsigned CNT_W = 3;

  localparam logic [CNT_W-1:0] LIMIT_MIN = 3'd1;
  localparam logic [CNT_W-1:0] LIMIT_MAX = 3'd4;
  localparam logic [CNT_W-1:0] LIMIT_RESET = 3'd3;

  localparam logic [3:0] PTYPE_PUBLISH = 4'd3;
  localparam logic [3:0] PTYPE_ID_FIRST = 4'd4;
  localparam logic [3:0] PTYPE_ID_LAST = 4'd11;

  typedef enum logic [1:0] {
    KIND_HEADER  = 2'd0,
    KIND_LENGTH  = 2'd1,
    KIND_PAYLOAD = 2'd2,
    KIND_ERROR   = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t            kind;
    logic [7:0]       data_byte;
    logic [3:0]       packet_type;
    logic [1:0]       qos_level;
    logic             dup_flag;
    logic [LEN_W-1:0] body_length;
    logic             last;
    logic [ID_W-1:0]  message_id;
  } result_t;

endpackage

[sv/mqd_if.sv]
// Valid/ready channel interfaces for the byte input and the result output.
interface mqd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface mqd_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  data_byte;
  logic [3:0]  packet_type;
  logic [1:0]  qos_level;
  logic        dup_flag;
  logic [27:0] body_length;
  logic        last;
  logic [15:0] message_id;

  modport source (output valid, output kind, output data_byte, output packet_type,
                  output qos_level, output dup_flag, output body_length, output last,
                  output message_id, input ready);
  modport sink (input valid, input kind, input data_byte, input packet_type,
                input qos_level, input dup_flag, input body_length, input last,
                input message_id, output ready);
endinterface

[sv/mqd_decoder.sv]
// Per-byte header, remaining-length and identifier decoding with packet state.
module mqd_decoder (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [2:0]       cfg_data,
  input  logic             step,
  input  logic [7:0]       rx_byte,
  output mqd_pkg::result_t res
);
  import mqd_pkg::*;

  typedef enum logic [2:0] {
    PH_HEADER  = 3'b001,
    PH_LENGTH  = 3'b010,
    PH_PAYLOAD = 3'b100
  } phase_t;

  phase_t           phase, phase_next;
  logic [7:0]       header_byte, header_byte_next;
  logic [LEN_W-1:0] length_acc, length_acc_next;
  logic [CNT_W-1:0] length_cnt, length_cnt_next;
  logic [LEN_W-1:0] payload_cnt, payload_cnt_next;
  logic [ID_W-1:0]  topic_length, topic_length_next;
  logic [ID_W-1:0]  id_reg, id_reg_next;
  logic [CNT_W-1:0] max_length_bytes;
  logic [CNT_W-1:0] limit;
  logic [LEN_W-1:0] addend;
  logic [LEN_W-1:0] topic_end;
  logic [3:0]       ptype;

  // Out-of-range limits clamp into 1..4.
  always_comb begin
    if (max_length_bytes < LIMIT_MIN) begin
      limit = LIMIT_MIN;
    end else if (max_length_bytes > LIMIT_MAX) begin
      limit = LIMIT_MAX;
    end else begin
      limit = max_length_bytes;
    end
  end

  always_comb begin
    case (length_cnt[1:0])
      2'd0:    addend = {21'b0, rx_byte[6:0]};
      2'd1:    addend = {14'b0, rx_byte[6:0], 7'b0};
      2'd2:    addend = {7'b0, rx_byte[6:0], 14'b0};
      default: addend = {rx_byte[6:0], 21'b0};
    endcase
  end

  assign ptype     = header_byte[7:4];
  assign topic_end = {{(LEN_W-ID_W){1'b0}}, topic_length} + LEN_W'(2);

  always_comb begin
    phase_next        = phase;
    header_byte_next  = header_byte;
    length_acc_next   = length_acc;
    length_cnt_next   = length_cnt;
    payload_cnt_next  = payload_cnt;
    topic_length_next = topic_length;
    id_reg_next       = id_reg;
    res.kind          = KIND_HEADER;
    res.body_length   = '0;
    res.last          = 1'b0;
    res.message_id    = '0;

    case (phase)
      PH_LENGTH: begin
        length_cnt_next = length_cnt + 3'd1;
        length_acc_next = length_acc + addend;
        res.body_length = length_acc_next;
        res.kind        = KIND_LENGTH;
        if (rx_byte[7]) begin
          if (length_cnt_next >= limit) begin
            res.kind   = KIND_ERROR;
            phase_next = PH_HEADER;
          end
        end else if (length_acc_next == '0) begin
          // Empty body: the final length byte closes the packet.
          res.last   = 1'b1;
          phase_next = PH_HEADER;
        end else begin
          payload_cnt_next = '0;
          phase_next       = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        res.kind = KIND_PAYLOAD;
        if (ptype >= PTYPE_ID_FIRST && ptype <= PTYPE_ID_LAST) begin
          if (payload_cnt == LEN_W'(0)) begin
            id_reg_next = {rx_byte, id_reg[7:0]};
          end else if (payload_cnt == LEN_W'(1)) begin
            id_reg_next = {id_reg[15:8], rx_byte};
          end
        end else if (ptype == PTYPE_PUBLISH) begin
          if (payload_cnt == LEN_W'(0)) begin
            topic_length_next = {rx_byte, topic_length[7:0]};
          end else if (payload_cnt == LEN_W'(1)) begin
            topic_length_next = {topic_length[15:8], rx_byte};
          end else if (header_byte[2:1] != 2'd0) begin
            if (payload_cnt == topic_end) begin
              id_reg_next = {rx_byte, id_reg[7:0]};
            end else if (payload_cnt == topic_end + LEN_W'(1)) begin
              id_reg_next = {id_reg[15:8], rx_byte};
            end
          end
        end
        payload_cnt_next = payload_cnt + LEN_W'(1);
        res.body_length  = length_acc;
        if (payload_cnt_next == length_acc) begin
          res.last       = 1'b1;
          res.message_id = id_reg_next;
          phase_next     = PH_HEADER;
        end
      end
      default: begin
        header_byte_next  = rx_byte;
        length_acc_next   = '0;
        length_cnt_next   = '0;
        payload_cnt_next  = '0;
        topic_length_next = '0;
        id_reg_next       = '0;
        phase_next        = PH_LENGTH;
      end
    endcase

    res.data_byte   = rx_byte;
    res.packet_type = header_byte_next[7:4];
    res.qos_level   = header_byte_next[2:1];
    res.dup_flag    = header_byte_next[3];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_HEADER;
      header_byte      <= '0;
      length_acc       <= '0;
      length_cnt       <= '0;
      payload_cnt      <= '0;
      topic_length     <= '0;
      id_reg           <= '0;
      max_length_bytes <= LIMIT_RESET;
    end else begin
      if (cfg_we) begin
        max_length_bytes <= cfg_data;
      end
      if (step) begin
        phase        <= phase_next;
        header_byte  <= header_byte_next;
        length_acc   <= length_acc_next;
        length_cnt   <= length_cnt_next;
        payload_cnt  <= payload_cnt_next;
        topic_length <= topic_length_next;
        id_reg       <= id_reg_next;
      end
    end
  end

  a_error_restarts: assert property (@(posedge clk) disable iff (rst)
    step && res.kind == KIND_ERROR |=> phase == PH_HEADER)
    else $error("length error did not return to header phase");

  a_last_restarts: assert property (@(posedge clk) disable iff (rst)
    step && res.last |=> phase == PH_HEADER)
    else $error("packet end did not return to header phase");

  a_id_only_on_last: assert property (@(posedge clk) disable iff (rst)
    step && !res.last |-> res.message_id == '0)
    else $error("message identifier given on a byte that is not last");

  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    length_cnt <= LIMIT_MAX)
    else $error("length byte count ran past the limit");

endmodule

[sv/mqd_out_buffer.sv]
// Two-entry output skid buffer for result beats.
module mqd_out_buffer (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  mqd_pkg::result_t in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output mqd_pkg::result_t out_data
);
  import mqd_pkg::*;

  result_t main_data, skid_data;
  logic    main_valid, skid_valid;
  logic    push, pop;

  assign in_ready  = !skid_valid;
  assign out_valid = main_valid;
  assign out_data  = main_data;
  assign push      = in_valid && in_ready;
  assign pop       = main_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!main_valid) begin
      main_valid <= push;
    end else if (pop) begin
      if (skid_valid) begin
        skid_valid <= 1'b0;
      end else begin
        main_valid <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!main_valid || (pop && !skid_valid)) begin
      main_data <= in_data;
    end else if (pop) begin
      main_data <= skid_data;
    end
    if (main_valid && !pop && push) begin
      skid_data <= in_data;
    end
  end

endmodule

[sv/mqtt_packet_deframer_unit.sv]
// Top level of the MQTT packet deframer: byte input, result output, limit register.
//
//   Channel  Dir  Beat contents
//   -------  ---  ----------------------------------------------------------------
//   rx       in   rx_byte: one received byte of the packet stream
//   tx       out  kind, data_byte, packet_type, qos_level, dup_flag, body_length,
//                 last, message_id: one result for each received byte
//   cfg      in   cfg_we / cfg_data: max_length_bytes, written at a clock edge with cfg_we high
//
// Every accepted byte produces exactly one result beat, which the output skid buffer registers.
// A byte can be accepted every cycle while the skid buffer has room; the decode is combinational.
// Reset is synchronous and active high; it returns to waiting for a header byte
// with a length-byte limit of 3.
// A two-entry skid buffer on the output keeps rx.ready registered, so a stalled
// tx channel holds back rx only once two results are waiting.
module mqtt_packet_deframer_unit (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [2:0] cfg_data,
  mqd_in_if.sink     rx,
  mqd_out_if.source  tx
);
  import mqd_pkg::*;

  result_t step_result;
  result_t buf_result;
  logic    step;

  // A byte is consumed when the skid buffer has room; the decoder state
  // advances on that same edge and its result is captured by the buffer.
  assign step = rx.valid && rx.ready;

  mqd_decoder u_decoder (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .step     (step),
    .rx_byte  (rx.rx_byte),
    .res      (step_result)
  );

  mqd_out_buffer u_out_buffer (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (rx.valid),
    .in_ready  (rx.ready),
    .in_data   (step_result),
    .out_valid (tx.valid),
    .out_ready (tx.ready),
    .out_data  (buf_result)
  );

  // Unpack the buffered result onto the output channel's fields.
  assign tx.kind        = buf_result.kind;
  assign tx.data_byte   = buf_result.data_byte;
  assign tx.packet_type = buf_result.packet_type;
  assign tx.qos_level   = buf_result.qos_level;
  assign tx.dup_flag    = buf_result.dup_flag;
  assign tx.body_length = buf_result.body_length;
  assign tx.last        = buf_result.last;
  assign tx.message_id  = buf_result.message_id;

endmodule
